// File: hw/rtl/triangle_tangent_bitangent_unit_defines.svh
// assertion macros for the triangle tangent and bitangent unit
`ifndef TRIANGLE_TANGENT_BITANGENT_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_BITANGENT_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TTB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TTB_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TTB_ASSERT(label, clk, rst, prop, msg)
`define TTB_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/ttb_pkg.sv
// types and constants shared by the tangent and bitangent unit
`timescale 1ns / 1ps
package ttb_pkg;
  localparam int PosW = 32;
  localparam int UvW = 16;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic mesh_end;
  } vertex_t;

  typedef struct packed {
    logic [1:0] vertex_slot;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic degenerate;
    logic count_error;
    logic run_last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic hold_vertex;  // store the vertex in slot
    logic hold_slot;
    logic load_tri;     // capture third vertex, form deltas
    logic calc_start;   // start products and divisions
  } dp_cmd_t;

  typedef struct packed {
    logic calc_done;
    logic degenerate;
  } dp_stat_t;
endpackage

// File: hw/rtl/ttb_divider.sv
// restoring divider, one quotient bit a cycle, signed with saturation
`timescale 1ns / 1ps
module ttb_divider #(
  parameter int NumW = 66,
  parameter int DenW = 33,
  parameter int FracBits = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [NumW-1:0] num,
  input  logic signed [DenW-1:0] den,
  output logic done,
  output logic [31:0] quot
);
  // quotient of (|num| << FracBits) / |den|, one bit per cycle
  localparam int QW = NumW + FracBits;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] dvd;
  logic [DenW:0] rem;
  logic [DenW-1:0] dsr;
  logic neg;
  logic [CW-1:0] cnt;
  logic busy;
  logic [DenW+1:0] trial;
  logic [QW-1:0] q;
  logic big;
  logic [NumW-1:0] an;
  logic [DenW-1:0] ad;

  assign an = num[NumW-1] ? NumW'(-num) : NumW'(num);
  assign ad = den[DenW-1] ? DenW'(-den) : DenW'(den);
  assign trial = {rem, dvd[QW-1]} - {2'b00, dsr};
  assign q = dvd;
  // any magnitude of 2^31 or more saturates either way
  assign big = |q[QW-1:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
        dvd  <= {an, FracBits'(0)};
        rem  <= '0;
        dsr  <= ad;
        neg  <= num[NumW-1] ^ den[DenW-1];
      end else if (busy) begin
        if (trial[DenW+1]) begin
          rem <= {rem[DenW-1:0], dvd[QW-1]};
          dvd <= {dvd[QW-2:0], 1'b0};
        end else begin
          rem <= trial[DenW:0];
          dvd <= {dvd[QW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      if (big || q[31]) quot = 32'h8000_0000;
      else quot = 32'(-q[31:0]);
    end else begin
      if (big || q[31]) quot = 32'h7FFF_FFFF;
      else quot = q[31:0];
    end
  end
endmodule

// File: hw/rtl/ttb_datapath.sv
// datapath: held vertices, deltas, products and a shared divider
`timescale 1ns / 1ps
module ttb_datapath #(
  parameter int UvFracBits = 12
) (
  input  logic clk,
  input  logic rst,
  input  ttb_pkg::vertex_t vin,
  input  ttb_pkg::dp_cmd_t cmd,
  output ttb_pkg::dp_stat_t stat,
  output logic signed [31:0] vec [6]
);
  logic signed [31:0] hp [6];
  logic signed [15:0] ht [4];
  logic signed [32:0] dp1 [3];
  logic signed [32:0] dp2 [3];
  logic signed [16:0] du1, dv1, du2, dv2;
  logic signed [33:0] det;
  logic signed [49:0] pa, pb;
  logic signed [65:0] num;
  logic [3:0] step;
  logic [2:0] idx;
  logic busy, div_start, div_done, det_ok;
  logic [31:0] quot;
  logic signed [32:0] ma;
  logic signed [16:0] mb1, mb2;
  logic [2:0] hbase;

  assign hbase = cmd.hold_slot ? 3'd3 : 3'd0;

  // step 0..: product pair for component idx, then divide, or zero when det is 0
  always_comb begin
    unique case (idx)
      3'd0, 3'd1, 3'd2: begin
        ma = dp1[idx[1:0]];
        mb1 = dv2;
        mb2 = dv1;
      end
      default: begin
        ma = dp2[2'(idx - 3'd3)];
        mb1 = du1;
        mb2 = du2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      idx <= '0;
      div_start <= 1'b0;
      stat <= '0;
    end else begin
      div_start <= 1'b0;
      stat.calc_done <= 1'b0;
      if (cmd.calc_start) begin
        busy <= 1'b1;
        idx <= '0;
        step <= '0;
      end else if (busy) begin
        unique case (step)
          4'd0: begin
            pa <= ma * mb1;
            step <= 4'd1;
          end
          4'd1: begin
            if (idx < 3'd3) pb <= dp2[idx[1:0]] * mb2;
            else pb <= dp1[2'(idx - 3'd3)] * mb2;
            step <= 4'd2;
          end
          4'd2: begin
            num <= 66'(pa) - 66'(pb);
            stat.degenerate <= (det == '0);
            if (det == '0) begin
              vec[idx] <= '0;
              step <= 4'd4;
            end else begin
              div_start <= 1'b1;
              step <= 4'd3;
            end
          end
          4'd3: begin
            if (div_done) begin
              vec[idx] <= quot;
              step <= 4'd4;
            end
          end
          default: begin
            step <= '0;
            if (idx == 3'd5) begin
              busy <= 1'b0;
              stat.calc_done <= 1'b1;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_vertex) begin
      hp[hbase] <= vin.pos_x;
      hp[hbase + 3'd1] <= vin.pos_y;
      hp[hbase + 3'd2] <= vin.pos_z;
      ht[{cmd.hold_slot, 1'b0}] <= vin.tex_u;
      ht[{cmd.hold_slot, 1'b1}] <= vin.tex_v;
    end
    if (cmd.load_tri) begin
      dp1[0] <= 33'(hp[3]) - 33'(hp[0]);
      dp1[1] <= 33'(hp[4]) - 33'(hp[1]);
      dp1[2] <= 33'(hp[5]) - 33'(hp[2]);
      dp2[0] <= 33'(vin.pos_x) - 33'(hp[0]);
      dp2[1] <= 33'(vin.pos_y) - 33'(hp[1]);
      dp2[2] <= 33'(vin.pos_z) - 33'(hp[2]);
      du1 <= 17'(ht[2]) - 17'(ht[0]);
      dv1 <= 17'(ht[3]) - 17'(ht[1]);
      du2 <= 17'(vin.tex_u) - 17'(ht[0]);
      dv2 <= 17'(vin.tex_v) - 17'(ht[1]);
    end
    det <= 34'(du1) * 34'(dv2) - 34'(dv1) * 34'(du2);
  end

  assign det_ok = (det != '0);

  ttb_divider #(.NumW(66), .DenW(34), .FracBits(UvFracBits)) u_div (
    .clk(clk), .rst(rst), .start(div_start && det_ok), .num(num), .den(det),
    .done(div_done), .quot(quot)
  );
endmodule

// File: hw/rtl/ttb_ctrl.sv
// controller: vertex count, triangle sequencing and result beats
`timescale 1ns / 1ps
`include "triangle_tangent_bitangent_unit_defines.svh"
module ttb_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_end,
  input  logic out_stall,
  output logic out_valid,
  output logic [1:0] slot,
  output logic err,
  output ttb_pkg::dp_cmd_t cmd,
  input  ttb_pkg::dp_stat_t stat
);
  typedef enum logic [2:0] {IDLE, WAITDET, CALC, EMIT, ERR} state_t;
  state_t state;
  logic [1:0] count;
  logic acc;

  assign in_stall = (state != IDLE);
  assign acc = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.hold_slot = count[0];
    cmd.hold_vertex = acc && !count[1] && !in_end;
    cmd.load_tri = acc && count[1];
    cmd.calc_start = (state == WAITDET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      out_valid <= 1'b0;
      slot <= '0;
      err <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (acc) begin
            if (count[1]) begin
              state <= WAITDET;
              count <= '0;
            end else if (in_end) begin
              count <= '0;
              state <= ERR;
              out_valid <= 1'b1;
              err <= 1'b1;
              slot <= '0;
            end else begin
              count <= count + 2'd1;
            end
          end
        end
        WAITDET: state <= CALC;
        CALC: begin
          if (stat.calc_done) begin
            state <= EMIT;
            out_valid <= 1'b1;
            err <= 1'b0;
            slot <= '0;
          end
        end
        EMIT: begin
          if (!out_stall) begin
            if (slot == 2'd2) begin
              out_valid <= 1'b0;
              state <= IDLE;
            end else begin
              slot <= slot + 2'd1;
            end
          end
        end
        default: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            err <= 1'b0;
            state <= IDLE;
          end
        end
      endcase
    end
  end

  `TTB_ASSERT(a_cnt_range, clk, rst, count != 2'd3, "vertex count out of range")
  `TTB_ASSERT(a_no_in_busy, clk, rst, (state != IDLE) |-> in_stall, "input taken while busy")
  `TTB_ASSERT(a_err_slot, clk, rst, (out_valid && err) |-> (slot == 2'd0), "error beat slot")
  `TTB_ASSERT_RST(a_rst_quiet, clk, rst |=> !out_valid, "output after reset")
endmodule

// File: hw/rtl/triangle_tangent_bitangent_unit.sv
// top level of the triangle tangent and bitangent unit
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_stall  | ttb_pkg::vertex_t
//  out     | out | out_valid / out_stall| ttb_pkg::result_t
// first two vertices of a triangle are taken without stalling the input
// third vertex: for each of six components, products then a 78-step bit-serial divide
//   (no divides when degenerate)
// then three result beats, one per cycle unless stalled
// a partial triangle at mesh end gives one error beat
// reset is synchronous; input is stalled from the third vertex until the last beat leaves
`timescale 1ns / 1ps
module triangle_tangent_bitangent_unit #(
  parameter int UV_FRAC_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  ttb_pkg::vertex_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output ttb_pkg::result_t out_data
);
  ttb_pkg::dp_cmd_t cmd;
  ttb_pkg::dp_stat_t stat;
  logic signed [31:0] vec [6];
  logic [1:0] slot;
  logic err;

  ttb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_end(in_data.mesh_end), .out_stall(out_stall), .out_valid(out_valid),
    .slot(slot), .err(err), .cmd(cmd), .stat(stat)
  );

  ttb_datapath #(.UvFracBits(UV_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .vin(in_data), .cmd(cmd), .stat(stat), .vec(vec)
  );

  always_comb begin
    out_data = '0;
    out_data.vertex_slot = slot;
    out_data.count_error = err;
    out_data.run_last = err || (slot == 2'd2);
    if (!err) begin
      out_data.tangent_x = vec[0];
      out_data.tangent_y = vec[1];
      out_data.tangent_z = vec[2];
      out_data.bitangent_x = vec[3];
      out_data.bitangent_y = vec[4];
      out_data.bitangent_z = vec[5];
      out_data.degenerate = stat.degenerate;
    end
  end
endmodule

// File: tb/triangle_tangent_bitangent_unit_test.sv
// testbench for the triangle tangent and bitangent unit: directed and random meshes
`timescale 1ns / 1ps
module triangle_tangent_bitangent_unit_test;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ttb_pkg::vertex_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ttb_pkg::result_t out_data;

  triangle_tangent_bitangent_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

  // predictor state
  logic signed [31:0] held_pos [2][3];
  logic signed [15:0] held_u [2];
  logic signed [15:0] held_v [2];
  int unsigned held_count = 0;
  ttb_pkg::result_t expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int triangles = 0;
  int degenerates = 0;
  int errors_sent = 0;
  int vertices_sent = 0;

  function automatic logic signed [31:0] tb_quotient(logic signed [63:0] num,
                                                    logic signed [63:0] det);
    logic neg;
    logic [63:0] un, ud, q1, r1, q;
    neg = (num < 0) != (det < 0);
    un = num < 0 ? -num : num;
    ud = det < 0 ? -det : det;
    q1 = un / ud;
    r1 = un % ud;
    if (q1 >= 64'd1 << 40) q = 64'd1 << 40;
    else q = (q1 << 12) + ((r1 << 12) / ud);
    if (neg) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return -q[31:0];
    end
    if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic queue_result(ttb_pkg::result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic predict_vertex(ttb_pkg::vertex_t vx);
    logic signed [63:0] dp1 [3], dp2 [3], tn [3], bt [3];
    logic signed [63:0] du1, dv1, du2, dv2, det;
    logic signed [31:0] cur [3];
    ttb_pkg::result_t r;
    cur[0] = vx.pos_x; cur[1] = vx.pos_y; cur[2] = vx.pos_z;
    if (held_count < 2) begin
      if (vx.mesh_end) begin
        held_count = 0;
        r = '0;
        r.count_error = 1'b1;
        r.run_last = 1'b1;
        queue_result(r);
        errors_sent++;
        return;
      end
      for (int i = 0; i < 3; i++) held_pos[held_count][i] = cur[i];
      held_u[held_count] = vx.tex_u;
      held_v[held_count] = vx.tex_v;
      held_count++;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      dp1[i] = 64'(held_pos[1][i]) - 64'(held_pos[0][i]);
      dp2[i] = 64'(cur[i]) - 64'(held_pos[0][i]);
    end
    du1 = 64'(held_u[1]) - 64'(held_u[0]);
    dv1 = 64'(held_v[1]) - 64'(held_v[0]);
    du2 = 64'(vx.tex_u) - 64'(held_u[0]);
    dv2 = 64'(vx.tex_v) - 64'(held_v[0]);
    det = du1 * dv2 - dv1 * du2;
    for (int i = 0; i < 3; i++) begin
      if (det == 0) begin
        tn[i] = 0; bt[i] = 0;
      end else begin
        tn[i] = 64'(tb_quotient(dp1[i] * dv2 - dp2[i] * dv1, det));
        bt[i] = 64'(tb_quotient(dp2[i] * du1 - dp1[i] * du2, det));
      end
    end
    for (int k = 0; k < 3; k++) begin
      r = '0;
      r.vertex_slot = 2'(k);
      r.tangent_x = tn[0][31:0]; r.tangent_y = tn[1][31:0]; r.tangent_z = tn[2][31:0];
      r.bitangent_x = bt[0][31:0]; r.bitangent_y = bt[1][31:0];
      r.bitangent_z = bt[2][31:0];
      r.degenerate = det == 0;
      r.run_last = k == 2;
      queue_result(r);
    end
    if (det == 0) degenerates++;
    triangles++;
    held_count = 0;
  endtask

  // sends one beat; prediction happens on acceptance
  task automatic send_vertex(ttb_pkg::vertex_t vx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= vx;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_vertex(vx);
    vertices_sent++;
    @(negedge clk);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_parts(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic signed [15:0] u,
                            logic signed [15:0] v, logic last);
    ttb_pkg::vertex_t vx;
    vx.pos_x = x; vx.pos_y = y; vx.pos_z = z;
    vx.tex_u = u; vx.tex_v = v; vx.mesh_end = last;
    send_vertex(vx);
  endtask

  function automatic ttb_pkg::vertex_t random_vertex(logic last);
    ttb_pkg::vertex_t vx;
    int sel;
    sel = $urandom_range(3);
    vx.pos_x = $urandom; vx.pos_y = $urandom; vx.pos_z = $urandom;
    vx.tex_u = 16'($urandom); vx.tex_v = 16'($urandom);
    if (sel == 0) begin
      vx.pos_x = $signed(16'($urandom)) <<< 8;
      vx.pos_y = $signed(16'($urandom)) <<< 8;
      vx.pos_z = $signed(16'($urandom)) <<< 8;
      vx.tex_u = $signed(6'($urandom)) <<< 6;
      vx.tex_v = $signed(6'($urandom)) <<< 6;
    end else if (sel == 1) begin
      vx.tex_u = $signed(3'($urandom));
      vx.tex_v = $signed(3'($urandom));
    end
    vx.mesh_end = last;
    return vx;
  endfunction

  task automatic wait_drained();
    stop_input();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // receiver: random stall or a long hold-off
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    ttb_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  want %p\n  got  %p", want, out_data);
        end
      end
    end
  end

  task automatic test_extremes();
    send_parts(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 16'sh8000, 16'sh8000, 0);
    send_parts(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh8000, 0);
    send_parts(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 16'sh7FFF, 0);
    // saturation with a tiny determinant
    send_parts(0, 0, 0, 0, 0, 0);
    send_parts(32'sh4000_0000, -32'sh4000_0000, 32'sh10000, 1, 0, 0);
    send_parts(-32'sh4000_0000, 32'sh4000_0000, 32'sh7FFF_FFFF, 0, 1, 0);
    send_parts(32'h1_0000, 32'h2_0000, 32'h3_0000, 16'h1000, 0, 0);
    send_parts(32'h2_0000, 32'h2_0000, 32'h3_0000, 16'h2000, 16'h0, 0);
    send_parts(32'h1_0000, 32'h3_0000, 32'h3_0000, 16'h1000, 16'h1000, 0);
    wait_drained();
  endtask

  task automatic test_degenerate();
    send_parts(32'h1_0000, 0, 0, 16'h0100, 16'h0100, 0);
    send_parts(32'h5_0000, 1, 2, 16'h0200, 16'h0200, 0);
    send_parts(32'h9_0000, 3, 4, 16'h0300, 16'h0300, 1);
    send_parts(-1, -1, -1, 16'h7FFF, 16'h7FFF, 0);
    send_parts(-1, -1, -1, 16'h7FFF, 16'h7FFF, 0);
    send_parts(-1, -1, -1, 16'h7FFF, 16'h7FFF, 0);
    wait_drained();
  endtask

  task automatic test_partial_mesh();
    send_parts(32'h1234_5678, 0, 0, 1, 1, 1);
    send_parts(32'h1, 2, 3, 4, 5, 0);
    send_parts(32'h6, 7, 8, 9, 10, 1);
    send_parts(32'h1, 2, 3, 4, 5, 0);
    send_parts(32'h6, 7, 8, 9, 10, 0);
    send_parts(32'h8765_4321, 7, 8, 9, 11, 1);
    wait_drained();
  endtask

  task automatic test_random_meshes(int n_vertices);
    int sent;
    int len;
    sent = 0;
    while (sent < n_vertices) begin
      len = $urandom_range(9) < 8 ? 3 * $urandom_range(1, 4) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_vertex(random_vertex(i == len - 1));
      sent += len;
    end
    stop_input();
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    recv_hold_cycles = 2000;
    for (int i = 0; i < 9; i++) send_vertex(random_vertex(i == 8));
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 0; recv_idle_pct = 0;
    test_extremes();
    test_degenerate();
    test_partial_mesh();
    send_idle_pct = 30; recv_idle_pct = 54;
    test_random_meshes(110);
    wait_drained();
    send_idle_pct = 54; recv_idle_pct = 30;
    test_random_meshes(110);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random_meshes(110);
    wait_drained();
    repeat (600) @(negedge clk);
    $display("sent %0d vertices: %0d triangles (%0d degenerate), %0d partial-mesh errors",
             vertices_sent, triangles, degenerates, errors_sent);
    $display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_divider.sv
hw/rtl/ttb_datapath.sv
hw/rtl/ttb_ctrl.sv
hw/rtl/triangle_tangent_bitangent_unit.sv
tb/triangle_tangent_bitangent_unit_test.sv
